>>> src/bldc_hall_commutation_tracker_unit_defines.svh
// Assertion macros used by the port-level checker of the hall commutation tracker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BLDC_HALL_COMMUTATION_TRACKER_UNIT_DEFINES_SVH
`define BLDC_HALL_COMMUTATION_TRACKER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHCT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BHCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bhct_pkg.sv
// Package for the hall commutation tracker: request and result types,
// mode and register codes, and the fixed lookup tables. Depends on nothing.
`default_nettype none

package bhct_pkg;

  typedef enum logic [1:0] {
    MODE_HALL_EDGE    = 2'd0,
    MODE_CTRL_TICK    = 2'd1,
    MODE_HOME_DRIVE   = 2'd2,
    MODE_HOME_CAPTURE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_PHASE_LEAD      = 2'd0,
    REG_TORQUE_WIDTH    = 2'd1,
    REG_REPORT_INTERVAL = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] hall_bits;
  } hall_req_t;

  typedef struct packed {
    logic [5:0]         drive_pattern;
    logic [9:0]         pulse_width;
    logic signed [31:0] rotor_position;
    logic signed [31:0] speed;
    logic               speed_report;
  } hall_rsp_t;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [9:0] MAX_PULSE       = 10'd1000;
  localparam logic [3:0] LEAD_RESET      = 4'd2;
  localparam logic [9:0] TORQUE_RESET    = 10'd300;
  localparam logic [7:0] INTERVAL_RESET  = 8'd10;

  localparam logic [5:0] DRIVE_LUT [8] = '{
    6'h12, 6'h18, 6'h09, 6'h21, 6'h24, 6'h06, 6'h00, 6'h00
  };

  localparam logic [2:0] ROTOR_LUT [8] = '{
    3'd7, 3'd5, 3'd3, 3'd4, 3'd1, 3'd0, 3'd2, 3'd7
  };

endpackage

`default_nettype wire

>>> src/bldc_hall_commutation_tracker_unit.sv
// Six-step hall commutation tracker for a brushless motor.
// Depends on bhct_pkg for the request and result types and the lookup tables.
//
// Usage:
//   Requests arrive on in_valid/in_ready/in_req, one mode and three raw hall bits
//   each. Every request yields exactly one result on out_valid/out_ready/out_rsp.
//   A request is decoded, applied to the tracking state and written into the
//   result register at the edge that accepts it, so its result shows on out_rsp
//   in the next cycle. One request per cycle is taken as long as the result
//   register is empty or being drained; the single result register sets that
//   figure. When the receiver stalls, the result holds in place and in_ready
//   falls until it is taken, so no result is lost or overwritten.
//   Reset (rst, synchronous) empties the result register, clears origin, last
//   rotor state, position, speed baseline and tick counter, and loads the
//   registers with lead 2, torque width 300 us and report interval 10.
//   Registers sit on the APB port at 0x0 (phase lead), 0x4 (torque width) and
//   0x8 (report interval); write them only while no request is in flight.
`default_nettype none

module bldc_hall_commutation_tracker_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire bhct_pkg::hall_req_t       in_req,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output bhct_pkg::hall_rsp_t            out_rsp,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [bhct_pkg::PADDR_W-1:0] paddr,
  input  wire logic [bhct_pkg::PDATA_W-1:0] pwdata,
  output logic [bhct_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import bhct_pkg::*;

  // Wrapped rotor steps of +5 and -5 in a 4-bit signed difference.
  localparam logic [3:0] STEP_FWD_WRAP  = 4'b0101;
  localparam logic [3:0] STEP_BACK_WRAP = 4'b1011;
  localparam logic [5:0] SUM_BIAS       = 6'd18;

  // Configuration registers.
  logic [3:0]  phase_lead;
  logic [9:0]  torque_width;
  logic [7:0]  report_interval;

  // Tracking state. pos_delta is position minus the position at the last tick.
  logic [2:0]  origin_state;
  logic [2:0]  last_rotor;
  logic [31:0] position_count;
  logic [31:0] pos_delta;
  logic [7:0]  tick_counter;

  logic        accept;
  logic        cfg_write;
  reg_idx_t    cfg_idx;
  mode_t       mode;
  logic [2:0]  rotor;
  logic [5:0]  comm_sum;
  logic [2:0]  comm_state;
  logic [3:0]  step;
  logic [31:0] step_ext;
  logic [31:0] position_count_next;
  logic [31:0] pos_delta_next;
  logic [31:0] speed_val;
  logic [9:0]  width_sat;
  logic        report_due;
  hall_rsp_t   out_rsp_next;

  function automatic logic [2:0] mod6(input logic [5:0] v);
    logic [5:0] t;
    t = v;
    if (t >= 6'd24) t = t - 6'd24;
    if (t >= 6'd12) t = t - 6'd12;
    if (t >= 6'd6)  t = t - 6'd6;
    return t[2:0];
  endfunction

  assign pready    = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_t'(paddr[3:2]);
  assign mode      = mode_t'(in_req.mode);
  assign rotor     = ROTOR_LUT[in_req.hall_bits];

  // The bias keeps the commutation sum positive (it spans 3 to 32), which
  // makes the remainder a true modulo even for a negative lead.
  assign comm_sum   = {3'b000, rotor} - {3'b000, origin_state}
                    + {{2{phase_lead[3]}}, phase_lead} + SUM_BIAS;
  assign comm_state = mod6(comm_sum);

  assign step = {1'b0, rotor} - {1'b0, last_rotor};

  always_comb begin
    case (step)
      STEP_FWD_WRAP:  step_ext = 32'hFFFF_FFFF;
      STEP_BACK_WRAP: step_ext = 32'd1;
      default:        step_ext = {{28{step[3]}}, step};
    endcase
  end

  assign width_sat  = (torque_width > MAX_PULSE) ? MAX_PULSE : torque_width;
  assign speed_val  = {pos_delta[28:0], 3'b000} + {pos_delta[30:0], 1'b0};
  assign report_due = tick_counter >= report_interval;

  always_comb begin
    position_count_next        = position_count;
    pos_delta_next             = pos_delta;
    out_rsp_next.drive_pattern = 6'd0;
    out_rsp_next.pulse_width   = 10'd0;
    out_rsp_next.speed         = 32'sd0;
    out_rsp_next.speed_report  = 1'b0;
    case (mode)
      MODE_HALL_EDGE: begin
        position_count_next        = position_count + step_ext;
        pos_delta_next             = pos_delta + step_ext;
        out_rsp_next.drive_pattern = DRIVE_LUT[comm_state];
        out_rsp_next.pulse_width   = width_sat;
      end
      MODE_CTRL_TICK: begin
        pos_delta_next            = 32'd0;
        out_rsp_next.speed        = speed_val;
        out_rsp_next.speed_report = report_due;
      end
      MODE_HOME_DRIVE: begin
        out_rsp_next.drive_pattern = DRIVE_LUT[0];
        out_rsp_next.pulse_width   = MAX_PULSE;
      end
      default: begin
      end
    endcase
    out_rsp_next.rotor_position = position_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_lead      <= LEAD_RESET;
      torque_width    <= TORQUE_RESET;
      report_interval <= INTERVAL_RESET;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_PHASE_LEAD:      phase_lead      <= pwdata[3:0];
        REG_TORQUE_WIDTH:    torque_width    <= pwdata[9:0];
        REG_REPORT_INTERVAL: report_interval <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PHASE_LEAD:      prdata = {28'd0, phase_lead};
      REG_TORQUE_WIDTH:    prdata = {22'd0, torque_width};
      REG_REPORT_INTERVAL: prdata = {24'd0, report_interval};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      origin_state   <= 3'd0;
      last_rotor     <= 3'd0;
      position_count <= 32'd0;
      pos_delta      <= 32'd0;
      tick_counter   <= 8'd0;
    end else begin
      if (accept) begin
        out_valid      <= 1'b1;
        position_count <= position_count_next;
        pos_delta      <= pos_delta_next;
        case (mode)
          MODE_HALL_EDGE:    last_rotor   <= rotor;
          MODE_CTRL_TICK:    tick_counter <= report_due ? 8'd0 : tick_counter + 8'd1;
          MODE_HOME_CAPTURE: origin_state <= rotor;
          default: begin
          end
        endcase
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_rsp <= out_rsp_next;
    end
  end

endmodule

`default_nettype wire

>>> src/bhct_checker.sv
// Port-level checks for the hall commutation tracker and the bind that attaches them.
// Depends on bhct_pkg and on the assertion macros in the defines header.
`default_nettype none
`include "bldc_hall_commutation_tracker_unit_defines.svh"

module bhct_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire bhct_pkg::hall_rsp_t  out_rsp
);
  import bhct_pkg::*;

  logic in_accept;
  logic out_stalled;
  logic report_shown;
  logic no_drive;

  assign in_accept    = in_valid && in_ready;
  assign out_stalled  = out_valid && !out_ready;
  assign report_shown = out_valid && out_rsp.speed_report;
  assign no_drive     = (out_rsp.drive_pattern == 6'd0) && (out_rsp.pulse_width == 10'd0);

  // An empty result register must never hold off a request.
  `BHCT_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready, "in_ready low while empty")

  // Every accepted request shows a result in the next cycle.
  `BHCT_ASSERT_NEXT(a_result_follows, in_accept, out_valid, "accepted request gave no result")

  // A velocity report comes only from a control tick, which drives no switches.
  `BHCT_ASSERT_SAME(a_report_no_drive, report_shown, no_drive, "report carries a drive pattern")

  `BHCT_ASSERT_NEXT(a_result_held, out_stalled, out_valid, "stalled result dropped")

  `BHCT_ASSERT_NEXT(a_payload_held, out_stalled, $stable(out_rsp), "stalled result changed")

endmodule

bind bldc_hall_commutation_tracker_unit bhct_checker u_bhct_checker (.*);

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for bldc_hall_commutation_tracker_unit.
// Random and directed requests go through valid/ready with APB register changes;
// a scoreboard class predicts each result. Depends on bhct_pkg and the unit.
import bhct_pkg::*;

class commutation_scoreboard;
  localparam int NUM_COMMUTATION_STATES = 6;
  localparam logic [31:0] SPEED_SCALE = 32'd10;

  logic [3:0]  lead;
  logic [9:0]  torque;
  logic [7:0]  interval;
  logic [2:0]  origin;
  logic [2:0]  last_rotor;
  logic [31:0] position;
  logic [31:0] prev_position;
  logic [7:0]  tick_count;
  hall_rsp_t   expected_rsp_q[$];
  int unsigned mismatches;

  function new();
    lead = LEAD_RESET;
    torque = TORQUE_RESET;
    interval = INTERVAL_RESET;
    origin = '0;
    last_rotor = '0;
    position = '0;
    prev_position = '0;
    tick_count = '0;
    mismatches = 0;
  endfunction

  function void set_register(reg_idx_t idx, logic [31:0] value);
    case (idx)
      REG_PHASE_LEAD:      lead = value[3:0];
      REG_TORQUE_WIDTH:    torque = value[9:0];
      REG_REPORT_INTERVAL: interval = value[7:0];
      default: ;
    endcase
  endfunction

  // Applies one accepted request to the tracking state and queues its result.
  function void note_request(hall_req_t req);
    hall_rsp_t rsp;
    logic [2:0] rotor;
    int lead_sum;
    int commutation;
    int delta;
    rsp = '0;
    rotor = ROTOR_LUT[req.hall_bits];
    case (mode_t'(req.mode))
      MODE_HALL_EDGE: begin
        // Invalid rotor code 7 takes part in the arithmetic as a plain number.
        lead_sum = int'(rotor) - int'(origin) + int'(signed'(lead)) + NUM_COMMUTATION_STATES;
        commutation = ((lead_sum % NUM_COMMUTATION_STATES) + NUM_COMMUTATION_STATES)
                      % NUM_COMMUTATION_STATES;
        delta = int'(rotor) - int'(last_rotor);
        if (delta == 5) delta = -1;
        else if (delta == -5) delta = 1;
        position = position + 32'(delta);
        last_rotor = rotor;
        rsp.drive_pattern = DRIVE_LUT[commutation];
        rsp.pulse_width = (torque > MAX_PULSE) ? MAX_PULSE : torque;
      end
      MODE_CTRL_TICK: begin
        rsp.speed = (position - prev_position) * SPEED_SCALE;
        prev_position = position;
        if (tick_count >= interval) begin
          tick_count = '0;
          rsp.speed_report = 1'b1;
        end else begin
          tick_count = tick_count + 8'd1;
        end
      end
      MODE_HOME_DRIVE: begin
        rsp.drive_pattern = DRIVE_LUT[0];
        rsp.pulse_width = MAX_PULSE;
      end
      default: origin = rotor;
    endcase
    rsp.rotor_position = position;
    expected_rsp_q.push_back(rsp);
  endfunction

  function string show(hall_rsp_t r);
    return $sformatf("pattern=%h width=%0d position=%0d speed=%0d report=%b",
                     r.drive_pattern, r.pulse_width, r.rotor_position, r.speed,
                     r.speed_report);
  endfunction

  function void check_result(hall_rsp_t got);
    hall_rsp_t want;
    if (expected_rsp_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: %s", show(got));
      return;
    end
    want = expected_rsp_q.pop_front();
    if (got.drive_pattern !== want.drive_pattern || got.pulse_width !== want.pulse_width ||
        got.rotor_position !== want.rotor_position || got.speed !== want.speed ||
        got.speed_report !== want.speed_report) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch expected: %s", show(want));
        $display("mismatch actual:   %s", show(got));
      end
    end
  endfunction

  function int pending();
    return expected_rsp_q.size();
  endfunction
endclass

module tb;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned PHASE_REQUESTS = 90;
  localparam logic [3:0] LEAD_PICKS [6] = '{4'h8, 4'h7, 4'hB, 4'h5, 4'h0, 4'hE};
  localparam logic [9:0] TORQUE_PICKS [6] = '{10'd0, 10'd1000, 10'd1001, 10'd1023,
                                               10'd512, 10'd1};
  localparam logic [7:0] INTERVAL_PICKS [6] = '{8'd0, 8'd255, 8'd1, 8'd3, 8'd7, 8'd0};

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  hall_req_t           in_req = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  hall_rsp_t           out_rsp;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  commutation_scoreboard sb = new();
  bit          no_idle = 1'b0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int          walk_rotor = 0;
  int          walk_dir = 1;
  logic [2:0]  hall_of_rotor [6];

  bldc_hall_commutation_tracker_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (no_idle || roll < 55) return 0;
    if (roll < 97) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Mostly a rotor turning one hall step at a time, with ticks and homing mixed in.
  function automatic hall_req_t next_request();
    hall_req_t r;
    int unsigned roll;
    roll = $urandom_range(99);
    r.hall_bits = 3'($urandom_range(7));
    if (roll < 60) begin
      if ($urandom_range(19) == 0) walk_dir = -walk_dir;
      walk_rotor = (walk_rotor + walk_dir + 6) % 6;
      r.mode = MODE_HALL_EDGE;
      r.hall_bits = hall_of_rotor[walk_rotor];
    end else if (roll < 68) begin
      r.mode = MODE_HALL_EDGE;
    end else if (roll < 86) begin
      r.mode = MODE_CTRL_TICK;
    end else if (roll < 93) begin
      r.mode = MODE_HOME_DRIVE;
    end else begin
      r.mode = MODE_HOME_CAPTURE;
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Holds the request until accepted; a draining request leaves valid low
  // until every result has come back.
  task automatic send_request(input hall_req_t r, input bit drain);
    int unsigned gap;
    gap = pick_gap();
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
    if (gap != 0 || drain) in_valid <= 1'b0;
    if (drain) wait_drained();
    repeat (gap) @(posedge clk);
  endtask

  task automatic send(input mode_t m, input logic [2:0] h, input bit drain);
    hall_req_t r;
    r.mode = m;
    r.hall_bits = h;
    send_request(r, drain);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, value);
  endtask

  task automatic apb_release();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_rsp);
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      out_ready <= (stall_left == 0);
      if (stall_left != 0) stall_left = stall_left - 1;
    end
  end

  initial begin
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [3:0] lead_pick;
    logic [9:0] torque_pick;
    logic [7:0] interval_pick;
    for (int h = 0; h < 8; h++) begin
      if (ROTOR_LUT[h] != 3'd7) hall_of_rotor[ROTOR_LUT[h]] = 3'(h);
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Every hall code under the reset settings, including both invalid codes.
    for (int h = 0; h < 8; h++) send(MODE_HALL_EDGE, 3'(h), 1'b0);
    send(MODE_CTRL_TICK, 3'd0, 1'b0);
    send(MODE_CTRL_TICK, 3'd7, 1'b0);
    send(MODE_HOME_DRIVE, 3'd5, 1'b0);
    // Capturing an invalid code makes the origin 7.
    send(MODE_HOME_CAPTURE, 3'd0, 1'b0);
    send(MODE_HALL_EDGE, 3'd7, 1'b0);
    send(MODE_HALL_EDGE, 3'd5, 1'b0);
    send(MODE_CTRL_TICK, 3'd2, 1'b1);

    // Most negative lead drives the commutation sum below zero; the interval
    // drops under the tick counter so the next tick reports at once.
    apb_write(REG_PHASE_LEAD, 32'h8);
    apb_write(REG_TORQUE_WIDTH, 32'd1023);
    apb_write(REG_REPORT_INTERVAL, 32'd2);
    apb_release();
    send(MODE_HALL_EDGE, 3'd5, 1'b0);
    send(MODE_HALL_EDGE, 3'd1, 1'b0);
    send(MODE_HALL_EDGE, 3'd5, 1'b0);
    send(MODE_CTRL_TICK, 3'd6, 1'b0);
    send(MODE_HOME_CAPTURE, 3'd3, 1'b0);
    send(MODE_HALL_EDGE, 3'd4, 1'b0);
    send(MODE_HOME_DRIVE, 3'd2, 1'b0);
    send(MODE_CTRL_TICK, 3'd1, 1'b1);

    for (int p = 0; p < 9; p++) begin
      no_idle = (p == 2) || (p == 6);
      if (p < 6) begin
        lead_pick = LEAD_PICKS[p];
        torque_pick = TORQUE_PICKS[p];
        interval_pick = INTERVAL_PICKS[p];
      end else begin
        lead_pick = 4'($urandom_range(15));
        torque_pick = 10'($urandom_range(1023));
        interval_pick = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                  : 8'($urandom_range(12));
      end
      apb_write(REG_PHASE_LEAD, 32'(lead_pick));
      apb_write(REG_TORQUE_WIDTH, 32'(torque_pick));
      apb_write(REG_REPORT_INTERVAL, 32'(interval_pick));
      apb_release();
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        send_request(next_request(), (n == PHASE_REQUESTS - 1) || ($urandom_range(59) == 0));
      end
    end

    wait_drained();
    // A few more cycles so that a stray result would still be caught.
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
